/* rtl/b32c_pkg.sv */
// Package: shared job type, constants and alphabet functions for the Base32 codec.
`default_nettype none
package b32c_pkg;

  localparam int unsigned JOBQ_DEPTH = 4;
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [4:0] LETTER_COUNT = 5'd26;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] DIGIT_OFS = 8'd24;  // '2' - 26
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_2 = 8'h32;
  localparam logic [7:0] CHAR_7 = 8'h37;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // One unit of work for the back end: data results first, then pad characters.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      ndata;
    logic [2:0]      npad;
    logic            stopped;
    logic            last;
  } job_t;

  function automatic logic [7:0] sym_char(input logic [4:0] v);
    logic [7:0] ofs;
    ofs = (v < LETTER_COUNT) ? CHAR_A : DIGIT_OFS;
    return {3'b000, v} + ofs;
  endfunction

  // bit 5: character is in the alphabet, bits 4:0: its value
  function automatic logic [5:0] char_sym(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHAR_A && c <= CHAR_Z) begin
      t = c - CHAR_A;
      return {1'b1, t[4:0]};
    end else if (c >= CHAR_2 && c <= CHAR_7) begin
      t = c - DIGIT_OFS;
      return {1'b1, t[4:0]};
    end
    return 6'd0;
  endfunction

endpackage
`default_nettype wire

/* rtl/b32c_front.sv */
// Front end: mode register, stream state, and per-item job formation.
`default_nettype none
module b32c_front
  import b32c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_mode,
  input  wire logic       acc,
  input  wire logic [7:0] data_in,
  input  wire logic       stream_last,
  output job_t            job,
  output logic            job_we
);

  mode_t       mode_r;
  logic [11:0] buf_r, buf_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [2:0]  gp_r, gp_nxt;
  logic        pbo_r, pbo_nxt;
  logic        halt_r, halt_nxt;

  // encode path
  logic [11:0] eb, ebuf1, ebuf2, ebufr, eflsh;
  logic [3:0]  ec, erem1, erem2, erem;
  logic [4:0]  es0, es1, esf;
  logic        etwo, eflush;
  logic [1:0]  ensym;
  logic [2:0]  egp, epad;
  logic [3:0]  ecap;

  // decode path
  logic [5:0]  sv;
  logic [11:0] db, db2, dpart, ppart;
  logic [3:0]  dc, dc2;
  logic [7:0]  dbyte;
  logic        dfull, dpbo2, dlast_part, stop_part;

  always_comb begin
    // encode
    eb    = {buf_r[3:0], data_in};
    ec    = {1'b0, bc_r[2:0]} + 4'd8;
    erem1 = ec - 4'd5;
    es0   = 5'(eb >> erem1);
    ebuf1 = eb & ((12'd1 << erem1) - 12'd1);
    etwo  = (erem1 >= 4'd5);
    erem2 = erem1 - 4'd5;
    es1   = 5'(ebuf1 >> erem2);
    ebuf2 = ebuf1 & ((12'd1 << erem2) - 12'd1);
    erem  = etwo ? erem2 : erem1;
    ebufr = etwo ? ebuf2 : ebuf1;
    eflsh = ebufr << (4'd5 - erem);
    esf   = eflsh[4:0];
    eflush = stream_last && (erem != 4'd0);
    ensym = (etwo ? 2'd2 : 2'd1) + {1'b0, eflush};
    egp   = gp_r + {1'b0, ensym};
    epad  = stream_last ? (3'd0 - egp) : 3'd0;
    ecap  = 4'd8 - {2'b00, ensym};
    if ({1'b0, epad} > ecap) epad = ecap[2:0];

    // decode
    sv    = char_sym(data_in);
    ppart = buf_r << (4'd8 - bc_r);
    stop_part = pbo_r && (bc_r != 4'd0) && (bc_r < 4'd8);
    db    = {buf_r[6:0], sv[4:0]};
    dc    = {1'b0, bc_r[2:0]} + 4'd5;
    dfull = (dc >= 4'd8);
    dbyte = 8'(db >> (dc - 4'd8));
    if (dfull) begin
      dc2   = dc - 4'd8;
      db2   = db & ((12'd1 << dc2) - 12'd1);
      dpbo2 = (db2 != 12'd0);
    end else begin
      dc2   = dc;
      db2   = db;
      dpbo2 = 1'b1;
    end
    dpart = db2 << (4'd8 - dc2);
    dlast_part = stream_last && dpbo2 && (dc2 != 4'd0) && (dc2 < 4'd8);

    job       = '0;
    job.last  = stream_last;
    buf_nxt   = buf_r;
    bc_nxt    = bc_r;
    gp_nxt    = gp_r;
    pbo_nxt   = pbo_r;
    halt_nxt  = halt_r;

    if (mode_r == MODE_ENCODE) begin
      job.data[0] = sym_char(es0);
      job.data[1] = sym_char(etwo ? es1 : esf);
      job.data[2] = sym_char(esf);
      job.ndata   = ensym;
      job.npad    = epad;
      buf_nxt     = ebufr;
      bc_nxt      = erem;
      gp_nxt      = egp;
    end else if (!halt_r) begin
      if (!sv[5]) begin
        job.data[0] = ppart[7:0];
        job.ndata   = {1'b0, stop_part};
        job.stopped = 1'b1;
        pbo_nxt     = 1'b0;
        halt_nxt    = 1'b1;
      end else begin
        job.data[0] = dfull ? dbyte : dpart[7:0];
        job.data[1] = dpart[7:0];
        job.ndata   = {1'b0, dfull} + {1'b0, dlast_part};
        buf_nxt     = db2;
        bc_nxt      = dc2;
        pbo_nxt     = dpbo2;
      end
    end

    if (stream_last) begin
      buf_nxt  = '0;
      bc_nxt   = '0;
      gp_nxt   = '0;
      pbo_nxt  = 1'b0;
      halt_nxt = 1'b0;
    end

    job_we = acc && ((job.ndata != 2'd0) || (job.npad != 3'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      buf_r  <= '0;
      bc_r   <= '0;
      gp_r   <= '0;
      pbo_r  <= 1'b0;
      halt_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_mode);
      buf_r  <= '0;
      bc_r   <= '0;
      gp_r   <= '0;
      pbo_r  <= 1'b0;
      halt_r <= 1'b0;
    end else if (acc) begin
      buf_r  <= buf_nxt;
      bc_r   <= bc_nxt;
      gp_r   <= gp_nxt;
      pbo_r  <= pbo_nxt;
      halt_r <= halt_nxt;
    end
  end

  a_halt_only_decode: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (mode_r == MODE_DECODE))
    else $error("decode halt set while encoding");

  a_bitcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r < 4'd8)
    else $error("pending bit count out of range");

endmodule
`default_nettype wire

/* rtl/b32c_jobq.sv */
// Job queue: small register FIFO between the front end and the back end.
`default_nettype none
module b32c_jobq
  import b32c_pkg::*;
#(
  parameter int unsigned DEPTH = JOBQ_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  job_t      wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      rd_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          q_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr_ok, rd_ok;

  always_comb begin
    full     = (cnt_r == CW'(DEPTH));
    rd_valid = (cnt_r != '0);
    rd_job   = q_r[rp_r];
    wr_ok    = wr_en && !full;
    rd_ok    = rd_en && rd_valid;
    wp_nxt   = wr_ok ? ((wp_r == LAST_PTR) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt   = rd_ok ? ((rp_r == LAST_PTR) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt  = cnt_r + CW'(wr_ok) - CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (wr_ok) q_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("job queue overfilled");

  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ok |-> ((wr_job.ndata != 2'd0) || (wr_job.npad != 3'd0)))
    else $error("job with no results queued");

endmodule
`default_nettype wire

/* rtl/b32c_back.sv */
// Back end: walks the head job, one result per cycle unless the output register stalls.
`default_nettype none
module b32c_back
  import b32c_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  job_t            job,
  input  wire logic       job_valid,
  output logic            job_done,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      data_out,
  output logic            run_last,
  output logic            stream_done,
  output logic            decode_stopped
);

  logic [2:0] idx_r, idx_nxt;
  logic       ov_r;
  logic [7:0] od_r;
  logic       orl_r, osd_r, ost_r;
  logic [3:0] total;
  logic       fin, adv;
  logic [7:0] res;

  always_comb begin
    total    = {2'b00, job.ndata} + {1'b0, job.npad};
    fin      = ({1'b0, idx_r} == (total - 4'd1));
    adv      = job_valid && (!ov_r || pop);
    res      = ({1'b0, idx_r} < {2'b00, job.ndata}) ? job.data[idx_r[1:0]] : PAD_CHAR;
    job_done = adv && fin;
    idx_nxt  = adv ? (fin ? 3'd0 : idx_r + 3'd1) : idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) ov_r <= 1'b1;
      else if (pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      od_r  <= res;
      orl_r <= fin;
      osd_r <= fin && job.last;
      ost_r <= job.stopped;
    end
  end

  assign empty          = !ov_r;
  assign data_out       = od_r;
  assign run_last       = orl_r;
  assign stream_done    = osd_r;
  assign decode_stopped = ost_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> ({1'b0, idx_r} < total))
    else $error("result index past end of job");

endmodule
`default_nettype wire

/* rtl/base32_stream_codec_unit.sv */
// Top level: streaming Base32 codec, front end + job queue + back end.
// Each job passes the job queue register before its results enter the output register.
// Throughput: one item per cycle while the job queue has room; one result per cycle while
//   the output is empty or popped, set by the single output register.
// An end-of-stream item may emit up to 8 results, one per cycle while they are popped.
// Reset (synchronous, rst_n low): mode returns to encode, stream state and queue clear.
`default_nettype none
module base32_stream_codec_unit
  import b32c_pkg::*;
#(
  parameter int unsigned JQ_DEPTH = JOBQ_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_mode,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_in,
  input  wire logic       in_stream_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_data_out,
  output logic            out_run_last,
  output logic            out_stream_done,
  output logic            out_decode_stopped
);

  job_t fr_job, hd_job;
  logic fr_we, hd_valid, hd_done, acc;

  assign cfg_ready = 1'b1;
  assign acc       = push && !full;

  b32c_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_mode    (cfg_mode),
    .acc         (acc),
    .data_in     (in_data_in),
    .stream_last (in_stream_last),
    .job         (fr_job),
    .job_we      (fr_we)
  );

  b32c_jobq #(.DEPTH(JQ_DEPTH)) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fr_we),
    .wr_job   (fr_job),
    .full     (full),
    .rd_en    (hd_done),
    .rd_job   (hd_job),
    .rd_valid (hd_valid)
  );

  b32c_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (hd_job),
    .job_valid      (hd_valid),
    .job_done       (hd_done),
    .empty          (empty),
    .pop            (pop),
    .data_out       (out_data_out),
    .run_last       (out_run_last),
    .stream_done    (out_stream_done),
    .decode_stopped (out_decode_stopped)
  );

endmodule
`default_nettype wire

/* dv/base32_stream_codec_unit_tb.sv */
// Testbench for base32_stream_codec_unit: directed and random streams in both modes.
`timescale 1ns / 1ps
module base32_stream_codec_unit_tb
  import b32c_pkg::*;
();

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
    logic       stopped;
  } codec_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_mode = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_data_in = 8'h00;
  logic       in_stream_last = 1'b0;
  logic       pop = 1'b0;
  logic       cfg_ready, full, empty;
  logic [7:0] out_data_out;
  logic       out_run_last, out_stream_done, out_decode_stopped;

  base32_stream_codec_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_mode          (cfg_mode),
    .push              (push),
    .full              (full),
    .in_data_in        (in_data_in),
    .in_stream_last    (in_stream_last),
    .empty             (empty),
    .pop               (pop),
    .out_data_out      (out_data_out),
    .out_run_last      (out_run_last),
    .out_stream_done   (out_stream_done),
    .out_decode_stopped(out_decode_stopped)
  );

  always #4 clk = ~clk;

  // codec model state
  mode_t       cur_mode = MODE_ENCODE;
  logic [11:0] acc_bits = '0;
  logic [3:0]  acc_cnt = '0;
  logic [2:0]  grp_pos = '0;
  logic        part_open = 1'b0;
  logic        dec_halted = 1'b0;
  codec_out_t  codec_out_q[$];

  int  n_fail = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_streams = 0;
  int  n_writes = 0;
  int  idle_cnt = 0;
  int  pop_wait = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  tx_idle_en = 1'b1;
  bit  rx_stall_en = 1'b1;
  bit  saw_full = 1'b0;

  function automatic logic [7:0] b32_char(input logic [4:0] v);
    logic [7:0] c;
    c = (v < 5'd26) ? 8'(v) + 8'h41 : 8'(v) - 8'd26 + 8'h32;
    return c;
  endfunction

  // bit 5 set when the character belongs to the alphabet
  function automatic logic [5:0] b32_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      return {1'b1, t[4:0]};
    end
    if (c >= 8'h32 && c <= 8'h37) begin
      t = c - 8'h32 + 8'd26;
      return {1'b1, t[4:0]};
    end
    return 6'd0;
  endfunction

  task automatic reset_stream_state();
    acc_bits = '0;
    acc_cnt = '0;
    grp_pos = '0;
    part_open = 1'b0;
    dec_halted = 1'b0;
  endtask

  task automatic codec_predict(input logic [7:0] d, input logic last, output bit skipped);
    codec_out_t batch[0:7];
    int         n;
    logic [4:0] sym;
    logic [5:0] dv;
    logic [3:0] c0;
    n = 0;
    skipped = 1'b0;
    if (cur_mode == MODE_ENCODE) begin
      acc_bits = {acc_bits[3:0], d};
      acc_cnt = {1'b0, acc_cnt[2:0]} + 4'd8;
      while (acc_cnt >= 4'd5) begin
        sym = 5'(acc_bits >> (acc_cnt - 4'd5));
        batch[n] = '{b32_char(sym), 1'b0, 1'b0, 1'b0};
        n++;
        grp_pos++;
        acc_cnt -= 4'd5;
        acc_bits &= (12'd1 << acc_cnt) - 12'd1;
      end
      if (last) begin
        if (acc_cnt > 0) begin
          sym = 5'(acc_bits << (4'd5 - acc_cnt));
          batch[n] = '{b32_char(sym), 1'b0, 1'b0, 1'b0};
          n++;
          grp_pos++;
        end
        while (grp_pos != 0 && n < 8) begin
          batch[n] = '{PAD_CHAR, 1'b0, 1'b0, 1'b0};
          n++;
          grp_pos++;
        end
      end
    end else if (dec_halted) begin
      skipped = 1'b1;
    end else begin
      dv = b32_value(d);
      if (!dv[5]) begin
        if (part_open && acc_cnt > 0 && acc_cnt < 8) begin
          batch[n] = '{8'(acc_bits << (4'd8 - acc_cnt)), 1'b0, 1'b0, 1'b1};
          n++;
        end
        part_open = 1'b0;
        dec_halted = 1'b1;
      end else begin
        c0 = {1'b0, acc_cnt[2:0]};
        acc_bits = {acc_bits[6:0], dv[4:0]};
        acc_cnt = c0 + 4'd5;
        if (acc_cnt >= 4'd8) begin
          batch[n] = '{8'(acc_bits >> (acc_cnt - 4'd8)), 1'b0, 1'b0, 1'b0};
          n++;
          acc_cnt -= 4'd8;
          acc_bits &= (12'd1 << acc_cnt) - 12'd1;
          part_open = (acc_bits != 0);
        end else begin
          part_open = 1'b1;
        end
        if (last) begin
          if (part_open && acc_cnt > 0 && acc_cnt < 8) begin
            batch[n] = '{8'(acc_bits << (4'd8 - acc_cnt)), 1'b0, 1'b0, 1'b0};
            n++;
          end
          part_open = 1'b0;
        end
      end
    end
    if (n > 0) begin
      batch[n-1].run_last = 1'b1;
      batch[n-1].done = last;
    end
    for (int i = 0; i < n; i++) codec_out_q = {codec_out_q, batch[i]};
    if (last) begin
      reset_stream_state();
      n_streams++;
    end
  endtask

  task automatic send_item(input logic [7:0] d, input logic last);
    int gap;
    bit skipped;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    in_data_in <= d;
    in_stream_last <= last;
    do @(posedge clk); while (full);
    codec_predict(d, last, skipped);
    if (!skipped) n_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (codec_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    drain_results();
    // items that make no result may still be in flight
    repeat (10) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cur_mode = m;
    reset_stream_state();
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_encode_stream(input bit finish);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), finish && i == len - 1);
  endtask

  task automatic rand_decode_stream(input bit finish);
    int         len;
    int         cut;
    bit         noisy;
    logic [7:0] c;
    len = $urandom_range(1, 16);
    cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy) c = 8'($urandom_range(0, 255));
      else if (i == cut) c = ($urandom_range(0, 1) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
      else c = b32_char(5'($urandom_range(0, 31)));
      send_item(c, finish && i == len - 1);
    end
  endtask

  task automatic test_encode_directed();
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    send_text("foo");
    send_text("foob");
    send_text("fooba");
  endtask

  task automatic test_decode_directed();
    write_mode(MODE_DECODE);
    send_text("7A2Z");
    send_text("MY@Q");
    send_text("A=");
  endtask

  task automatic test_sender_pause();
    write_mode(MODE_ENCODE);
    write_mode(MODE_ENCODE);
    for (int i = 0; i < 3; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
    drain_results();
    for (int i = 0; i < 2; i++) send_item(8'($urandom_range(0, 255)), i == 1);
  endtask

  task automatic test_output_backpressure();
    write_mode(MODE_ENCODE);
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (3) for (int i = 0; i < 10; i++) send_item(8'($urandom_range(0, 255)), i == 9);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_streams(input int target);
    int    stop_at;
    mode_t m;
    stop_at = n_items + target;
    while (n_items < stop_at) begin
      m = mode_t'($urandom_range(0, 1));
      write_mode(m);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_stall_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        if (m == MODE_ENCODE) rand_encode_stream(1'b1);
        else rand_decode_stream(1'b1);
      end
      // stream left open; the next mode write discards it
      if ($urandom_range(0, 4) == 0) begin
        if (m == MODE_ENCODE) rand_encode_stream(1'b0);
        else rand_decode_stream(1'b0);
      end
    end
  endtask

  // result side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop_wait--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    codec_out_t e;
    if (rst_n && pop && !empty) begin
      n_results++;
      if (codec_out_q.size() == 0) begin
        n_fail++;
        $error("unexpected transfer: data_out=%02h", out_data_out);
      end else begin
        e = codec_out_q.pop_front();
        if (out_data_out !== e.data) begin
          n_fail++;
          $error("data_out: expected %02h, actual %02h", e.data, out_data_out);
        end
        if (out_run_last !== e.run_last) begin
          n_fail++;
          $error("run_last: expected %0b, actual %0b", e.run_last, out_run_last);
        end
        if (out_stream_done !== e.done) begin
          n_fail++;
          $error("stream_done: expected %0b, actual %0b", e.done, out_stream_done);
        end
        if (out_decode_stopped !== e.stopped) begin
          n_fail++;
          $error("decode_stopped: expected %0b, actual %0b", e.stopped, out_decode_stopped);
        end
      end
      pop_wait = rx_stall_en ? $urandom_range(0, 5) : 0;
    end
  end

  always @(posedge clk) begin
    if (push && full) saw_full <= 1'b1;
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("[base32_stream_codec_unit] ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_encode_directed();
    test_decode_directed();
    test_sender_pause();
    test_output_backpressure();
    test_random_streams(170);
    drain_results();
    repeat (10) @(posedge clk);
    if (codec_out_q.size() != 0) begin
      n_fail++;
      $error("%0d results never arrived", codec_out_q.size());
    end
    $display("Run covered %0d items and %0d streams over %0d mode writes; %0d results checked.",
             n_items, n_streams, n_writes, n_results);
    $display("Input backpressure observed: %s", saw_full ? "yes" : "no");
    if (n_fail == 0) $display("[base32_stream_codec_unit] OK");
    else $display("[base32_stream_codec_unit] ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/b32c_pkg.sv
rtl/b32c_front.sv
rtl/b32c_jobq.sv
rtl/b32c_back.sv
rtl/base32_stream_codec_unit.sv
dv/base32_stream_codec_unit_tb.sv
